// ===== design/bmw_pkg.sv =====
// Package: sizes, item structs and command/status types for the tree queue
`timescale 1ns / 1ps
`default_nettype none
package bmw_pkg;
  localparam int TreeDepth   = 8;
  localparam int RankBits    = 32;
  localparam int PayloadBits = 16;
  localparam int NodeCount   = (1 << TreeDepth) - 1;
  localparam int LvlBits     = $clog2(TreeDepth + 1);
  localparam int NodeBits    = TreeDepth;
  localparam int CntBits     = $clog2(2 * NodeCount + 1);
  localparam int EntryBits   = RankBits + PayloadBits;
  // one node word: two slots of {valid, count, rank, payload}
  localparam int SlotBits    = 1 + CntBits + EntryBits;
  localparam int WordBits    = 2 * SlotBits;

  localparam logic [1:0] StatDone  = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;
  localparam logic       FuncPush  = 1'b0;
  localparam logic       FuncPop   = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [RankBits-1:0]    rank;
    logic [PayloadBits-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [RankBits-1:0]    out_rank;
    logic [PayloadBits-1:0] out_payload;
  } out_item_t;

  typedef struct packed {
    logic                   vld;
    logic [CntBits-1:0]     cnt;
    logic [RankBits-1:0]    rank;
    logic [PayloadBits-1:0] payload;
  } slot_t;

  typedef struct packed {
    slot_t s1;
    slot_t s0;
  } node_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;  // write one zero node word of the clearing pass
    logic load;   // capture input item, start at root
    logic step;   // evaluate node word, write back, advance
    logic finish; // build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done; // clearing pass writes its last word
    logic reject;   // full push or empty pop
    logic last;     // operation completes at this node
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== design/bmw_ram.sv =====
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
`default_nettype none
module bmw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/bmw_datapath.sv =====
// Datapath: node memory with clearing pass, walk registers and result
`timescale 1ns / 1ps
`default_nettype none
module bmw_datapath
  import bmw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dp_cmd_t   cmd,
  input  wire in_item_t  in_item,
  output dp_stat_t       stat,
  output out_item_t      result
);
  localparam int AddrBits = $clog2(NodeCount);

  logic [CntBits-1:0]     total_r, total_nxt;
  logic [AddrBits-1:0]    clr_r;     // clearing pass address
  logic                   func_r;
  logic [RankBits-1:0]    rank_r;
  logic [PayloadBits-1:0] pay_r;
  logic [NodeBits-1:0]    node_r;    // node number, root is 1
  logic [LvlBits-1:0]     lvl_r;
  logic                   gsel_r;    // pop: slot vacated in parent
  logic [NodeBits-1:0]    pnode_r;   // pop: parent node number
  logic                   first_r;
  logic                   rej_r;
  logic [RankBits-1:0]    orank_r;
  logic [PayloadBits-1:0] opay_r;
  out_item_t              res_r;

  node_t                  rd_word, wr_word;
  logic [WordBits-1:0]    rd_raw;
  logic                   we;
  logic [AddrBits-1:0]    waddr;
  // parent word kept for pop write-back of the slot being refilled
  node_t                  par_r;

  bmw_ram #(.Width(WordBits), .Depth(NodeCount)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wr_word),
    .raddr(AddrBits'(node_r - 1'b1)),
    .rdata(rd_raw)
  );

  // current node word
  always_comb begin
    rd_word = node_t'(rd_raw);
  end

  function automatic logic less(input logic [RankBits-1:0] ra, input logic [PayloadBits-1:0] pa,
                                input logic [RankBits-1:0] rb, input logic [PayloadBits-1:0] pb);
    less = (ra < rb) || (ra == rb && pa < pb);
  endfunction

  logic sm;        // smaller slot of current node
  logic gl;        // push: lighter slot
  logic swap;
  slot_t ks, cs;   // selected slot / child-smaller slot
  logic empty_node;
  logic past_bottom;

  always_comb begin
    sm = 1'b0;
    if (!rd_word.s0.vld) sm = rd_word.s1.vld;
    else if (rd_word.s1.vld)
      sm = less(rd_word.s1.rank, rd_word.s1.payload, rd_word.s0.rank, rd_word.s0.payload);
    gl   = rd_word.s0.cnt > rd_word.s1.cnt;
    ks   = gl ? rd_word.s1 : rd_word.s0;
    swap = less(rank_r, pay_r, ks.rank, ks.payload);
    cs   = sm ? rd_word.s1 : rd_word.s0;
    // below the bottom level there is nothing to move up
    past_bottom = (lvl_r == LvlBits'(TreeDepth));
    empty_node  = past_bottom || (!rd_word.s0.vld && !rd_word.s1.vld);
  end

  // status: a step is the last when push lands or pop chain ends
  always_comb begin
    stat.clr_done = (clr_r == AddrBits'(NodeCount - 1));
    stat.reject   = rej_r;
    if (func_r == FuncPush)
      stat.last = !rd_word.s0.vld || !rd_word.s1.vld;
    else
      stat.last = !first_r && empty_node;
  end

  // write data for this step
  always_comb begin
    we      = 1'b0;
    waddr   = AddrBits'(node_r - 1'b1);
    wr_word = rd_word;
    if (cmd.clear) begin
      we      = 1'b1;
      waddr   = clr_r;
      wr_word = '0;
    end else if (cmd.step) begin
      if (func_r == FuncPush) begin
        we = 1'b1;
        if (!rd_word.s0.vld || !rd_word.s1.vld) begin
          if (!rd_word.s0.vld) begin
            wr_word.s0.vld = 1'b1;
            wr_word.s0.rank = rank_r; wr_word.s0.payload = pay_r;
          end else begin
            wr_word.s1.vld = 1'b1;
            wr_word.s1.rank = rank_r; wr_word.s1.payload = pay_r;
          end
        end else if (gl) begin
          wr_word.s1.cnt = rd_word.s1.cnt + 1'b1;
          if (swap) begin
            wr_word.s1.rank = rank_r; wr_word.s1.payload = pay_r;
          end
        end else begin
          wr_word.s0.cnt = rd_word.s0.cnt + 1'b1;
          if (swap) begin
            wr_word.s0.rank = rank_r; wr_word.s0.payload = pay_r;
          end
        end
      end else if (!first_r) begin
        // pop: refill parent slot gsel_r from this node's smaller slot
        we      = 1'b1;
        waddr   = AddrBits'(pnode_r - 1'b1);
        wr_word = par_r;
        if (empty_node) begin
          // nothing below: the parent slot goes empty
          if (gsel_r) wr_word.s1.vld = 1'b0;
          else wr_word.s0.vld = 1'b0;
        end else if (gsel_r) begin
          wr_word.s1.rank = cs.rank; wr_word.s1.payload = cs.payload;
          if (par_r.s1.cnt != '0) wr_word.s1.cnt = par_r.s1.cnt - 1'b1;
        end else begin
          wr_word.s0.rank = cs.rank; wr_word.s0.payload = cs.payload;
          if (par_r.s0.cnt != '0) wr_word.s0.cnt = par_r.s0.cnt - 1'b1;
        end
      end
    end
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.finish && !rej_r)
      total_nxt = (func_r == FuncPush) ? total_r + 1'b1 : total_r - 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      clr_r   <= '0;
    end else begin
      total_r <= total_nxt;
      if (cmd.clear) clr_r <= clr_r + 1'b1;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_item.func;
      rank_r  <= in_item.rank;
      pay_r   <= in_item.payload;
      node_r  <= NodeBits'(1);
      lvl_r   <= '0;
      first_r <= 1'b1;
      orank_r <= '0;
      opay_r  <= '0;
      rej_r   <= (in_item.func == FuncPush) ? (total_r == CntBits'(2 * NodeCount))
                                            : (total_r == '0);
    end else if (cmd.step) begin
      first_r <= 1'b0;
      lvl_r   <= lvl_r + 1'b1;
      if (func_r == FuncPush) begin
        node_r <= {node_r[NodeBits-2:0], gl};
        if (swap) begin
          rank_r <= ks.rank;
          pay_r  <= ks.payload;
        end
      end else begin
        if (first_r) begin
          orank_r <= cs.rank;
          opay_r  <= cs.payload;
        end
        // this node is not written in this step, so its word stands as read
        par_r   <= rd_word;
        pnode_r <= node_r;
        gsel_r  <= sm;
        node_r  <= {node_r[NodeBits-2:0], sm};
      end
    end
    if (cmd.finish) begin
      res_r.status      <= rej_r ? ((func_r == FuncPush) ? StatFull : StatEmpty) : StatDone;
      res_r.out_rank    <= (rej_r || func_r == FuncPush) ? '0 : orank_r;
      res_r.out_payload <= (rej_r || func_r == FuncPush) ? '0 : opay_r;
    end
  end

  assign result = res_r;
endmodule
`default_nettype wire

// ===== design/bmw_ctrl.sv =====
// Controller: per-item sequencing over tree levels and output handshake
`timescale 1ns / 1ps
`default_nettype none
module bmw_ctrl
  import bmw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);
  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_CHK  = 6'b000100,
    S_RD   = 6'b001000,
    S_EVAL = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_CLR: begin
        // clearing pass over the node memory after reset
        cmd.clear = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK:  state_nxt = stat.reject ? S_FIN : S_RD;
      S_RD:   state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.step  = 1'b1;
        state_nxt = stat.last ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

// ===== design/bmw_tree_priority_queue.sv =====
// Top level: two-way balanced tree priority queue
//
//  channel  ports                            direction
//  input    in_valid in_ready in_item        push/pop request
//  output   out_valid out_ready out_item     status and popped entry
//
// After reset a clearing pass zeroes all NodeCount (255) node words, in_ready low.
// An item is handled in steps: check, then per level a read and an evaluate/write-back,
// then finish; out_valid is registered from finish, and the next item is taken in
// only after finish. Push visits at most TreeDepth levels, pop TreeDepth+1 (a last
// write-back step after the bottom level); rejects go from check straight to finish.
// A waiting result stalls the finish of the next item, not its transfer in.
`timescale 1ns / 1ps
`default_nettype none
module bmw_tree_priority_queue
  import bmw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  bmw_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item),
    .stat(stat), .result(out_item)
  );
endmodule
`default_nettype wire

// ===== bench/tb_bmw_tree_priority_queue.sv =====
// Testbench for the two-way tree priority queue: push/pop traffic checked against a tree model
`timescale 1ns / 1ps
module tb_bmw_tree_priority_queue
  import bmw_pkg::*;
();

  localparam int Slots = 2 * NodeCount;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  bmw_tree_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // tree model state
  logic                   q_vld [Slots];
  logic [RankBits-1:0]    q_rank [Slots];
  logic [PayloadBits-1:0] q_pay [Slots];
  int unsigned            q_cnt [Slots];
  int unsigned            q_total;

  out_item_t pending_results[$];
  int  errors;
  int  n_items, n_results, n_pops, n_full, n_empty;
  longint cycles = 0;
  int  out_hold;
  bit  drain_wait;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit entry_lt(logic [RankBits-1:0] ra, logic [PayloadBits-1:0] pa,
                                  logic [RankBits-1:0] rb, logic [PayloadBits-1:0] pb);
    return (ra < rb) || (ra == rb && pa < pb);
  endfunction

  function automatic int pick_min(int s);
    if (!q_vld[s]) return q_vld[s+1] ? 1 : 0;
    if (!q_vld[s+1]) return 0;
    return entry_lt(q_rank[s+1], q_pay[s+1], q_rank[s], q_pay[s]) ? 1 : 0;
  endfunction

  // predicted result for one request; updates the model tree
  function automatic out_item_t queue_predict(in_item_t it);
    out_item_t res;
    logic [RankBits-1:0] r, tr;
    logic [PayloadBits-1:0] p, tp;
    int n, s, g, k, c, cs, g2, k2;
    bit placed;
    res = '0;
    n = 1;
    if (it.func == FuncPush) begin
      r = it.rank;
      p = it.payload;
      if (q_total >= Slots) begin
        res.status = StatFull;
        return res;
      end
      placed = 0;
      for (int lvl = 0; lvl < TreeDepth && !placed; lvl++) begin
        s = 2 * (n - 1);
        if (!q_vld[s] || !q_vld[s+1]) begin
          k = q_vld[s] ? s + 1 : s;
          q_vld[k] = 1'b1;
          q_rank[k] = r;
          q_pay[k] = p;
          q_total++;
          placed = 1;
        end else begin
          g = (q_cnt[s] > q_cnt[s+1]) ? 1 : 0;
          k = s + g;
          if (entry_lt(r, p, q_rank[k], q_pay[k])) begin
            tr = q_rank[k]; tp = q_pay[k];
            q_rank[k] = r;  q_pay[k] = p;
            r = tr;         p = tp;
          end
          q_cnt[k]++;
          n = 2 * n + g;
        end
      end
      res.status = StatDone;
      return res;
    end
    if (q_total == 0) begin
      res.status = StatEmpty;
      return res;
    end
    g = pick_min(0);
    k = g;
    res.status = StatDone;
    res.out_rank = q_rank[k];
    res.out_payload = q_pay[k];
    for (int lvl = 0; ; lvl++) begin
      if (lvl + 1 >= TreeDepth) begin
        q_vld[k] = 1'b0;
        break;
      end
      c = 2 * n + g;
      cs = 2 * (c - 1);
      if (!q_vld[cs] && !q_vld[cs+1]) begin
        q_vld[k] = 1'b0;
        break;
      end
      g2 = pick_min(cs);
      k2 = cs + g2;
      q_rank[k] = q_rank[k2];
      q_pay[k] = q_pay[k2];
      if (q_cnt[k] > 0) q_cnt[k]--;
      k = k2;
      n = c;
      g = g2;
    end
    q_total--;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
  endtask

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // send one request; the model is updated when the transfer happens
  task automatic send_request(logic func, logic [RankBits-1:0] rank,
                              logic [PayloadBits-1:0] payload);
    in_item_t it;
    int gap;
    gap = drain_wait ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.func = func;
    it.rank = rank;
    it.payload = payload;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(queue_predict(it));
    n_items++;
    if (func == FuncPop) n_pops++;
  endtask

  task automatic push_entry(logic [RankBits-1:0] r, logic [PayloadBits-1:0] p);
    send_request(FuncPush, r, p);
  endtask

  task automatic pop_entry();
    send_request(FuncPop, RankBits'($urandom), PayloadBits'($urandom));
  endtask

  // result side: random stalls, compare each transfer
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_item, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status != want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.out_rank != want.out_rank)
            report_mismatch("rank", out_item.out_rank, want.out_rank);
          if (out_item.out_payload != want.out_payload)
            report_mismatch("payload", out_item.out_payload, want.out_payload);
          if (want.status == StatFull) n_full++;
          if (want.status == StatEmpty) n_empty++;
        end
      end
      // one ready cycle, then a random stall
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold  <= out_hold - 1;
      end else begin
        out_ready <= 1'b1;
        out_hold  <= gap_len();
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * TreeDepth + 10) @(posedge clk);
  endtask

  // empty queue pops, then extreme ranks and payloads, ties broken by payload
  task automatic test_directed();
    pop_entry();
    push_entry('1, '1);
    push_entry('0, '0);
    push_entry(32'h8000_0000, 16'h0001);
    push_entry(32'h8000_0000, 16'h0000);
    push_entry(32'h0000_0005, 16'hFFFF);
    push_entry(32'h0000_0005, 16'h7FFF);
    push_entry(32'hFFFF_FFFF, 16'h0000);
    repeat (8) pop_entry();
    push_entry(32'h1234_5678, 16'hABCD);
    pop_entry();
    pop_entry();
    wait_drained();
  endtask

  // fill to capacity, hit the full flag, then drain past empty
  task automatic test_full_drain();
    for (int i = 0; i < Slots; i++)
      push_entry(RankBits'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom),
                 PayloadBits'($urandom));
    push_entry('0, '0);
    push_entry(RankBits'($urandom), PayloadBits'($urandom));
    for (int i = 0; i < Slots + 2; i++) pop_entry();
    wait_drained();
  endtask

  // random mixes with drifting push bias so the depth wanders over the tree
  task automatic test_random(int count);
    int bias;
    logic [RankBits-1:0] r;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) bias = $urandom_range(25, 80);
      if ($urandom_range(0, 99) < bias) begin
        case ($urandom_range(0, 3))
          0: r = $urandom_range(0, 7);
          1: r = '1 - $urandom_range(0, 3);
          default: r = $urandom;
        endcase
        push_entry(r, PayloadBits'($urandom));
      end else begin
        pop_entry();
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    errors = 0;
    n_items = 0; n_results = 0; n_pops = 0; n_full = 0; n_empty = 0;
    drain_wait = 0;
    for (int i = 0; i < Slots; i++) begin
      q_vld[i] = 1'b0; q_rank[i] = '0; q_pay[i] = '0; q_cnt[i] = 0;
    end
    q_total = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_drain();
    test_random(1650 - 2 * Slots - 40);
    $display("covered %0d requests (%0d pops), %0d results, %0d full drops, %0d empty pops",
             n_items, n_pops, n_results, n_full, n_empty);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== bmw_tree_priority_queue.f =====
design/bmw_pkg.sv
design/bmw_ram.sv
design/bmw_datapath.sv
design/bmw_ctrl.sv
design/bmw_tree_priority_queue.sv
bench/tb_bmw_tree_priority_queue.sv
